// ===== src/pcs_pkg.sv =====
// Package for the path component splitter: byte class word, result word
// and character codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pcs_pkg;

	localparam int OFFSET_W = 13;

	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_END  = 1'b1;

	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_NUL    = 8'h00;

	// Classified word handed from the front end to the parser.
	typedef struct packed {
		logic is_end;   // end of path word
		logic keep;     // byte is within the length limit
		logic ovf;      // on an end word: bytes were dropped
		logic slash;
		logic bslash;
		logic dot;
		logic nul;
		logic letter;
		logic colon;
	} pcs_cls_t;

	localparam int CLS_W = $bits(pcs_cls_t);

	typedef struct packed {
		logic [OFFSET_W-1:0] root_end;
		logic [OFFSET_W-1:0] dir_end;
		logic [OFFSET_W-1:0] base_start;
		logic [OFFSET_W-1:0] ext_start;
		logic [OFFSET_W-1:0] name_end;
		logic                need_separator;
		logic                too_long;
	} pcs_result_t;

	function automatic pcs_cls_t classify(input logic kind, input logic [7:0] c);
		pcs_cls_t r;
		r        = '0;
		r.is_end = (kind == KIND_END);
		r.slash  = (c == CH_SLASH);
		r.bslash = (c == CH_BSLASH);
		r.dot    = (c == CH_DOT);
		r.nul    = (c == CH_NUL);
		r.colon  = (c == CH_COLON);
		r.letter = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/pcs_in_if.sv =====
// Input channel of the path component splitter: valid/ready plus one path word.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pcs_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] path_byte;

	modport source (output valid, output kind, output path_byte, input ready);
	modport sink (input valid, input kind, input path_byte, output ready);
endinterface

`default_nettype wire

// ===== src/pcs_out_if.sv =====
// Output channel of the path component splitter: valid/ready plus the split result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface pcs_out_if;
	logic        valid;
	logic        ready;
	logic [12:0] root_end;
	logic [12:0] dir_end;
	logic [12:0] base_start;
	logic [12:0] ext_start;
	logic [12:0] name_end;
	logic        need_separator;
	logic        too_long;

	modport source (output valid, output root_end, output dir_end, output base_start,
		output ext_start, output name_end, output need_separator, output too_long,
		input ready);
	modport sink (input valid, input root_end, input dir_end, input base_start,
		input ext_start, input name_end, input need_separator, input too_long,
		output ready);
endinterface

`default_nettype wire

// ===== src/pcs_fifo.sv =====
// Two-entry register queue between the front end and the parser.
// Depends on nothing; the width is set by the instantiating module.
`timescale 1ns / 1ps
`default_nettype none

module pcs_fifo #(
	parameter int WIDTH = 8
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (cnt_q != 2'd2);
	assign pop_valid  = (cnt_q != 2'd0);
	assign pop_data   = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (do_pop) begin
				rd_q <= ~rd_q;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

// ===== src/pcs_front.sv =====
// Front end: accepts path words, counts byte offsets, flags bytes past the
// length limit and classifies each byte. Depends on pcs_pkg and pcs_in_if.
`timescale 1ns / 1ps
`default_nettype none

module pcs_front #(
	parameter int MAX_LEN = 4096,
	parameter int POS_W   = 13
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	pcs_in_if.sink                               path_in,
	output logic                                 push_valid,
	input  wire logic                            push_ready,
	output logic [POS_W+pcs_pkg::CLS_W-1:0]      push_data
);
	import pcs_pkg::*;

	logic [POS_W-1:0] pos_q;
	logic             ovf_q;
	logic             accept;
	logic             room;
	pcs_cls_t         cls;

	assign path_in.ready = push_ready;
	assign push_valid    = path_in.valid;
	assign accept        = path_in.valid && push_ready;
	assign room          = (pos_q != POS_W'(MAX_LEN));

	always_comb begin
		cls      = classify(path_in.kind, path_in.path_byte);
		cls.keep = room;
		cls.ovf  = ovf_q;
	end

	// The offset sent with an end word is the path length.
	assign push_data = {pos_q, cls};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			if (path_in.kind == KIND_END) begin
				pos_q <= '0;
				ovf_q <= 1'b0;
			end else if (room) begin
				pos_q <= pos_q + 1'b1;
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== src/pcs_scan.sv =====
// Streaming path scanner for one separator mode: tracks root, last component
// and extension offsets one byte at a time. Depends on pcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pcs_scan #(
	parameter int POS_W = 13
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             win,
	input  wire logic             step,
	input  wire logic             clear,
	input  wire pcs_pkg::pcs_cls_t cls,
	input  wire logic [POS_W-1:0] pos,
	output logic [POS_W-1:0]      root_end,
	output logic [POS_W-1:0]      dir_end,
	output logic [POS_W-1:0]      base_start,
	output logic [POS_W-1:0]      ext_start,
	output logic [POS_W-1:0]      name_end,
	output logic                  need_sep
);
	import pcs_pkg::*;

	localparam logic [2:0] PH_ROOT     = 3'd0;
	localparam logic [2:0] PH_UNC_SEPS = 3'd1;
	localparam logic [2:0] PH_UNC_NAME = 3'd2;
	localparam logic [2:0] PH_SEPS     = 3'd3;
	localparam logic [2:0] PH_LEAD     = 3'd4;
	localparam logic [2:0] PH_NAME     = 3'd5;
	localparam logic [2:0] PH_DONE     = 3'd6;

	logic [2:0]       phase_q, phase_n;
	logic [POS_W-1:0] root_q, root_n;
	logic [POS_W-1:0] dir_q, dir_n;
	logic [POS_W-1:0] base_q, base_n;
	logic [POS_W-1:0] ext_q, ext_n;
	logic [POS_W-1:0] name_q, name_n;
	logic             has_comp_q, has_comp_n;
	logic             ext_v_q, ext_v_n;
	logic             dot_last_q, dot_last_n;
	logic             last_sep_q;
	logic             b0_sep_q;
	logic             b0_let_q;
	logic             sep;
	logic             start_c;
	logic [POS_W-1:0] pos1;
	logic             at_second;

	assign sep       = cls.slash || (win && cls.bslash);
	assign pos1      = pos + 1'b1;
	assign at_second = win && (pos == POS_W'(1));

	always_comb begin
		phase_n    = phase_q;
		root_n     = root_q;
		dir_n      = dir_q;
		base_n     = base_q;
		ext_n      = ext_q;
		name_n     = name_q;
		has_comp_n = has_comp_q;
		ext_v_n    = ext_v_q;
		dot_last_n = dot_last_q;
		start_c    = 1'b0;

		unique case (phase_q)
			PH_ROOT: begin
				if (sep) begin
					root_n = pos1;
				end else if (cls.nul) begin
					phase_n = PH_DONE;
				end else begin
					start_c = 1'b1;
				end
			end
			PH_SEPS: begin
				if (cls.nul) begin
					phase_n = PH_DONE;
				end else if (!sep) begin
					start_c = 1'b1;
				end
			end
			PH_LEAD: begin
				if (sep) begin
					phase_n = PH_SEPS;
				end else if (cls.nul) begin
					phase_n = PH_DONE;
				end else begin
					name_n = pos1;
					if (!cls.dot) begin
						phase_n = PH_NAME;
					end
				end
			end
			PH_NAME: begin
				if (sep) begin
					phase_n = PH_SEPS;
				end else if (cls.nul) begin
					phase_n = PH_DONE;
				end else begin
					name_n     = pos1;
					dot_last_n = cls.dot;
					if (cls.dot) begin
						ext_n   = pos;
						ext_v_n = 1'b1;
					end
				end
			end
			PH_UNC_SEPS: begin
				if (cls.nul) begin
					phase_n = PH_DONE;
				end else begin
					root_n = pos1;
					if (!sep) begin
						phase_n = PH_UNC_NAME;
					end
				end
			end
			PH_UNC_NAME: begin
				if (cls.nul) begin
					phase_n = PH_DONE;
				end else begin
					root_n = pos1;
					if (sep) begin
						phase_n = PH_SEPS;
					end
				end
			end
			PH_DONE: begin
			end
			default: begin
				phase_n = PH_DONE;
			end
		endcase

		if (start_c) begin
			has_comp_n = 1'b1;
			dir_n      = has_comp_q ? name_q : root_q;
			base_n     = pos;
			ext_v_n    = 1'b0;
			dot_last_n = 1'b0;
			name_n     = pos1;
			phase_n    = cls.dot ? PH_LEAD : PH_NAME;
		end

		// In Windows mode the second byte decides a server root or a drive root; either
		// overrides whatever the plain parse made of the first two bytes.
		if (at_second && b0_sep_q && sep) begin
			phase_n    = PH_UNC_SEPS;
			root_n     = POS_W'(2);
			has_comp_n = 1'b0;
		end else if (at_second && b0_let_q && cls.colon) begin
			phase_n    = PH_ROOT;
			root_n     = POS_W'(2);
			has_comp_n = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_ROOT;
			root_q     <= '0;
			has_comp_q <= 1'b0;
			last_sep_q <= 1'b0;
		end else if (clear) begin
			phase_q    <= PH_ROOT;
			root_q     <= '0;
			has_comp_q <= 1'b0;
			last_sep_q <= 1'b0;
		end else if (step) begin
			phase_q    <= phase_n;
			root_q     <= root_n;
			has_comp_q <= has_comp_n;
			last_sep_q <= sep;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			dir_q      <= dir_n;
			base_q     <= base_n;
			ext_q      <= ext_n;
			name_q     <= name_n;
			ext_v_q    <= ext_v_n;
			dot_last_q <= dot_last_n;
			if (pos == '0) begin
				b0_sep_q <= sep;
				b0_let_q <= cls.letter;
			end
		end
	end

	// Sampled on an end word, where pos carries the path length.
	always_comb begin
		root_end = root_q;
		if (has_comp_q) begin
			dir_end    = dir_q;
			base_start = base_q;
			name_end   = name_q;
			ext_start  = (ext_v_q && !dot_last_q) ? ext_q : name_q;
		end else begin
			dir_end    = root_q;
			base_start = '0;
			name_end   = root_q;
			ext_start  = root_q;
		end
		if (pos == '0) begin
			need_sep = 1'b1;
		end else begin
			need_sep = !((root_q == pos) || last_sep_q);
		end
	end

endmodule

`default_nettype wire

// ===== src/pcs_back.sv =====
// Back end: drains the classified queue through a POSIX and a Windows scanner,
// picks one on each end word and holds the result in an output register.
// Depends on pcs_pkg, pcs_scan and pcs_out_if.
`timescale 1ns / 1ps
`default_nettype none

module pcs_back #(
	parameter int POS_W = 13
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             win_mode,
	input  wire logic                             q_valid,
	output logic                                  q_ready,
	input  wire logic [POS_W+pcs_pkg::CLS_W-1:0]  q_data,
	pcs_out_if.source                             split_out
);
	import pcs_pkg::*;

	pcs_cls_t         cls;
	logic [POS_W-1:0] pos;
	logic             slot_free;
	logic             pop;
	logic             step;
	logic             clear;
	logic             out_valid_q;
	pcs_result_t      res_q;

	logic [POS_W-1:0] px_root, px_dir, px_base, px_ext, px_name;
	logic [POS_W-1:0] wn_root, wn_dir, wn_base, wn_ext, wn_name;
	logic             px_need, wn_need;

	assign cls       = q_data[CLS_W-1:0];
	assign pos       = q_data[CLS_W +: POS_W];
	assign slot_free = !out_valid_q || split_out.ready;
	// Byte words never produce a result, so only end words wait for the slot.
	assign q_ready   = !cls.is_end || slot_free;
	assign pop       = q_valid && q_ready;
	assign step      = pop && !cls.is_end && cls.keep;
	assign clear     = pop && cls.is_end;

	pcs_scan #(.POS_W(POS_W)) u_scan_posix (
		.clk        (clk),
		.arst_n     (arst_n),
		.win        (1'b0),
		.step       (step),
		.clear      (clear),
		.cls        (cls),
		.pos        (pos),
		.root_end   (px_root),
		.dir_end    (px_dir),
		.base_start (px_base),
		.ext_start  (px_ext),
		.name_end   (px_name),
		.need_sep   (px_need)
	);

	pcs_scan #(.POS_W(POS_W)) u_scan_win (
		.clk        (clk),
		.arst_n     (arst_n),
		.win        (1'b1),
		.step       (step),
		.clear      (clear),
		.cls        (cls),
		.pos        (pos),
		.root_end   (wn_root),
		.dir_end    (wn_dir),
		.base_start (wn_base),
		.ext_start  (wn_ext),
		.name_end   (wn_name),
		.need_sep   (wn_need)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (clear) begin
			out_valid_q <= 1'b1;
		end else if (split_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (clear) begin
			if (win_mode) begin
				res_q.root_end       <= OFFSET_W'(wn_root);
				res_q.dir_end        <= OFFSET_W'(wn_dir);
				res_q.base_start     <= OFFSET_W'(wn_base);
				res_q.ext_start      <= OFFSET_W'(wn_ext);
				res_q.name_end       <= OFFSET_W'(wn_name);
				res_q.need_separator <= wn_need;
			end else begin
				res_q.root_end       <= OFFSET_W'(px_root);
				res_q.dir_end        <= OFFSET_W'(px_dir);
				res_q.base_start     <= OFFSET_W'(px_base);
				res_q.ext_start      <= OFFSET_W'(px_ext);
				res_q.name_end       <= OFFSET_W'(px_name);
				res_q.need_separator <= px_need;
			end
			res_q.too_long <= cls.ovf;
		end
	end

	assign split_out.valid          = out_valid_q;
	assign split_out.root_end       = res_q.root_end;
	assign split_out.dir_end        = res_q.dir_end;
	assign split_out.base_start     = res_q.base_start;
	assign split_out.ext_start      = res_q.ext_start;
	assign split_out.name_end       = res_q.name_end;
	assign split_out.need_separator = res_q.need_separator;
	assign split_out.too_long       = res_q.too_long;

endmodule

`default_nettype wire

// ===== src/path_component_splitter.sv =====
// Path component splitter. One word per cycle is accepted while the queue has room;
// an end word passes the queue register, then the output register. Throughput is
// one word per cycle while end words find the output slot free, bounded by the
// byte-at-a-time scanner update. Reset clears the offset counter, the queue,
// both scanners and win_q (POSIX).
// Depends on pcs_pkg, pcs_in_if, pcs_out_if, pcs_front, pcs_fifo and pcs_back.
`timescale 1ns / 1ps
`default_nettype none

module path_component_splitter #(
	parameter int MAX_LEN = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pcs_in_if.sink    path_in,
	pcs_out_if.source split_out,
	input  wire logic cfg_we,
	input  wire logic cfg_wdata
);
	import pcs_pkg::*;

	localparam int POS_W = $clog2(MAX_LEN + 1);
	localparam int Q_W   = POS_W + CLS_W;

	logic           win_q;
	logic           push_valid;
	logic           push_ready;
	logic [Q_W-1:0] push_data;
	logic           q_valid;
	logic           q_ready;
	logic [Q_W-1:0] q_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 1'b0;
		end else if (cfg_we) begin
			win_q <= cfg_wdata;
		end
	end

	pcs_front #(.MAX_LEN(MAX_LEN), .POS_W(POS_W)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.path_in    (path_in),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	pcs_fifo #(.WIDTH(Q_W)) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_data   (q_data)
	);

	pcs_back #(.POS_W(POS_W)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_mode  (win_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.split_out (split_out)
	);

endmodule

`default_nettype wire
